### rtl/epsc_pkg.sv
// ----------------------------------------------------------------------------
// epsc_pkg
// Shared types, constants and month tables for the epoch seconds to
// calendar converter.
// ----------------------------------------------------------------------------
package epsc_pkg;

   // pipeline depth: input register, four work stages, result register
   localparam int Stages = 6;

   // stage register load enables from the pipeline control
   typedef struct packed {
      logic [Stages-1:0] load;
   } stage_ctrl_type;

   // seconds are split as (seconds >> 7) / 675, since 86400 = 128 * 675
   localparam int DayShift = 7;
   localparam logic [9:0] DayDivisor = 10'd675;
   // exact reciprocal of 675 for 25-bit operands: ceil(2^35 / 675)
   localparam logic [25:0] DayRecip = 26'd50903317;
   localparam int DayRecipShift = 35;

   // four-year cycle of 1461 days, reciprocal exact for 16-bit operands
   localparam logic [10:0] CycleDays = 11'd1461;
   localparam logic [16:0] CycleRecip = 17'd91868;
   localparam int CycleRecipShift = 27;

   // year boundaries inside one four-year cycle
   localparam logic [10:0] Year1Start = 11'd366;
   localparam logic [10:0] Year2Start = 11'd731;
   localparam logic [10:0] Year3Start = 11'd1096;

   // divide by 60, exact for 17-bit operands (seconds of day)
   localparam logic [5:0] Sixty = 6'd60;
   localparam logic [17:0] MinRecip = 18'd139811;
   localparam int MinRecipShift = 23;
   // divide by 60, exact for 11-bit operands (minutes of day)
   localparam logic [11:0] HourRecip = 12'd2185;
   localparam int HourRecipShift = 17;

   // cumulative month starts, entry 0 is January
   localparam logic [12:0][8:0] CommonStart = {
      9'd365, 9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
      9'd151, 9'd120, 9'd90, 9'd59, 9'd31, 9'd0};
   localparam logic [12:0][8:0] LeapStart = {
      9'd366, 9'd335, 9'd305, 9'd274, 9'd244, 9'd213, 9'd182,
      9'd152, 9'd121, 9'd91, 9'd60, 9'd31, 9'd0};

   // first day of year for a month index (0 is January)
   function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
      logic [8:0] val;
      if (idx > 4'd12) begin
         val = 9'd0;
      end else if (leap) begin
         val = LeapStart[idx];
      end else begin
         val = CommonStart[idx];
      end
      return val;
   endfunction

endpackage

### rtl/epsc_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// epsc_pipe_ctrl
// Valid bits and load enables for the conversion pipeline; a stage moves
// forward when the next one is empty or moving, so bubbles collapse.
// ----------------------------------------------------------------------------
module epsc_pipe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output epsc_pkg::stage_ctrl_type ctrl
);

   localparam int N = epsc_pkg::Stages;

   logic [N-1:0] valid_ff;
   logic [N-1:0] valid_in;
   logic [N-1:0] adv;

   // advance chain from the result end backward
   always_comb begin
      adv[N-1] = !valid_ff[N-1] || !rsp_stall;
      for (int i = N - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   // next valid bits
   always_comb begin
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < N; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load = adv;
   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[N-1];

endmodule

### rtl/epsc_day_split.sv
// ----------------------------------------------------------------------------
// epsc_day_split
// Splits the seconds count into day number, seconds of day and the
// four-year cycle number over three registered stages.
// ----------------------------------------------------------------------------
module epsc_day_split (
   input  logic                     clock,
   input  epsc_pkg::stage_ctrl_type ctrl,
   input  logic [31:0]              req_seconds,
   output logic [15:0]              days,
   output logic [5:0]               cycle,
   output logic [16:0]              tod
);

   logic [31:0] secs_ff;
   logic [15:0] days2_ff;
   logic [24:0] units2_ff;
   logic [6:0]  low2_ff;
   logic [15:0] days3_ff;
   logic [5:0]  cycle3_ff;
   logic [16:0] tod3_ff;

   logic [50:0] day_prod;
   logic [15:0] days2_in;
   logic [24:0] rem_full;
   logic [16:0] tod3_in;
   logic [32:0] cycle_prod;
   logic [5:0]  cycle3_in;

   // input register
   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         secs_ff <= req_seconds;
      end
   end

   // day number from seconds / 128 times reciprocal of 675
   assign day_prod = 51'(secs_ff[31:epsc_pkg::DayShift]) * 51'(epsc_pkg::DayRecip);
   assign days2_in = day_prod[epsc_pkg::DayRecipShift +: 16];

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         days2_ff  <= days2_in;
         units2_ff <= secs_ff[31:epsc_pkg::DayShift];
         low2_ff   <= secs_ff[epsc_pkg::DayShift-1:0];
      end
   end

   // seconds of day and four-year cycle number
   assign rem_full   = units2_ff - 25'(days2_ff) * 25'(epsc_pkg::DayDivisor);
   assign tod3_in    = {rem_full[9:0], low2_ff};
   assign cycle_prod = 33'(days2_ff) * 33'(epsc_pkg::CycleRecip);
   assign cycle3_in  = cycle_prod[epsc_pkg::CycleRecipShift +: 6];

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         days3_ff  <= days2_ff;
         cycle3_ff <= cycle3_in;
         tod3_ff   <= tod3_in;
      end
   end

   assign days  = days3_ff;
   assign cycle = cycle3_ff;
   assign tod   = tod3_ff;

endmodule

### rtl/epsc_date.sv
// ----------------------------------------------------------------------------
// epsc_date
// Turns day number and cycle number into year offset, month and day of
// month by year boundaries and the cumulative month tables.
// ----------------------------------------------------------------------------
module epsc_date (
   input  logic                     clock,
   input  epsc_pkg::stage_ctrl_type ctrl,
   input  logic [15:0]              days,
   input  logic [5:0]               cycle,
   output logic [7:0]               year,
   output logic [3:0]               month,
   output logic [4:0]               day
);

   logic [10:0] dic4_ff;
   logic [5:0]  cycle4_ff;
   logic [7:0]  year5_ff;
   logic [3:0]  month5_ff;
   logic [4:0]  day5_ff;
   logic [7:0]  year6_ff;
   logic [3:0]  month6_ff;
   logic [4:0]  day6_ff;

   logic [15:0] dic_full;
   logic [1:0]  yoff;
   logic [10:0] doy_full;
   logic        leap;
   logic [3:0]  month5_in;
   logic [8:0]  day_full;

   // day within the four-year cycle
   assign dic_full = days - 16'(cycle) * 16'(epsc_pkg::CycleDays);

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         dic4_ff   <= dic_full[10:0];
         cycle4_ff <= cycle;
      end
   end

   // year within the cycle; the first year of each cycle is leap
   always_comb begin
      if (dic4_ff < epsc_pkg::Year1Start) begin
         yoff     = 2'd0;
         doy_full = dic4_ff;
         leap     = 1'b1;
      end else if (dic4_ff < epsc_pkg::Year2Start) begin
         yoff     = 2'd1;
         doy_full = dic4_ff - epsc_pkg::Year1Start;
         leap     = 1'b0;
      end else if (dic4_ff < epsc_pkg::Year3Start) begin
         yoff     = 2'd2;
         doy_full = dic4_ff - epsc_pkg::Year2Start;
         leap     = 1'b0;
      end else begin
         yoff     = 2'd3;
         doy_full = dic4_ff - epsc_pkg::Year3Start;
         leap     = 1'b0;
      end
   end

   // month: last table entry not above the day of year
   always_comb begin
      month5_in = 4'd1;
      for (int i = 1; i < 12; i++) begin
         if (doy_full[8:0] >= epsc_pkg::month_start(leap, 4'(i))) begin
            month5_in = 4'(i + 1);
         end
      end
   end

   assign day_full = doy_full[8:0] - epsc_pkg::month_start(leap, month5_in - 4'd1) + 9'd1;

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         year5_ff  <= {cycle4_ff, yoff};
         month5_ff <= month5_in;
         day5_ff   <= day_full[4:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         year6_ff  <= year5_ff;
         month6_ff <= month5_ff;
         day6_ff   <= day5_ff;
      end
   end

   assign year  = year6_ff;
   assign month = month6_ff;
   assign day   = day6_ff;

endmodule

### rtl/epsc_clock.sv
// ----------------------------------------------------------------------------
// epsc_clock
// Splits seconds of day into hour, minute and second with reciprocal
// multiplies by 1/60 and registered remainders.
// ----------------------------------------------------------------------------
module epsc_clock (
   input  logic                     clock,
   input  epsc_pkg::stage_ctrl_type ctrl,
   input  logic [16:0]              tod,
   output logic [4:0]               hour,
   output logic [5:0]               minute,
   output logic [5:0]               second
);

   logic [10:0] mins4_ff;
   logic [16:0] tod4_ff;
   logic [4:0]  hour5_ff;
   logic [10:0] mins5_ff;
   logic [5:0]  sec5_ff;
   logic [4:0]  hour6_ff;
   logic [5:0]  minute6_ff;
   logic [5:0]  sec6_ff;

   logic [34:0] mins_prod;
   logic [16:0] sec_full;
   logic [22:0] hour_prod;
   logic [10:0] minute_full;

   // minutes of day
   assign mins_prod = 35'(tod) * 35'(epsc_pkg::MinRecip);

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         mins4_ff <= mins_prod[epsc_pkg::MinRecipShift +: 11];
         tod4_ff  <= tod;
      end
   end

   // second of minute and hour of day
   assign sec_full  = tod4_ff - 17'(mins4_ff) * 17'(epsc_pkg::Sixty);
   assign hour_prod = 23'(mins4_ff) * 23'(epsc_pkg::HourRecip);

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         hour5_ff <= hour_prod[epsc_pkg::HourRecipShift +: 5];
         mins5_ff <= mins4_ff;
         sec5_ff  <= sec_full[5:0];
      end
   end

   // minute of hour into the result register
   assign minute_full = mins5_ff - 11'(hour5_ff) * 11'(epsc_pkg::Sixty);

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         hour6_ff   <= hour5_ff;
         minute6_ff <= minute_full[5:0];
         sec6_ff    <= sec5_ff;
      end
   end

   assign hour   = hour6_ff;
   assign minute = minute6_ff;
   assign second = sec6_ff;

endmodule

### rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 2000-01-01 00:00:00 into year offset, month, day,
// hour, minute and second; every fourth year is leap.
// ----------------------------------------------------------------------------
//   channel   ports                          direction
//   req       req_valid req_stall req_seconds  in  (32-bit seconds)
//   rsp       rsp_valid rsp_stall rsp_*        out (year..second)
//
// One transfer per cycle in and out while rsp is not stalled; a request passes
// through an input register, four stages of reciprocal multiplies and table
// compares, and the result register before rsp_valid rises.
// Synchronous reset clears the stage valid bits; data registers are not reset.
// A stall on rsp holds the result; empty stages keep filling, and req_stall
// rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   epsc_pkg::stage_ctrl_type ctrl;
   logic [15:0] days;
   logic [5:0]  cycle;
   logic [16:0] tod;

   // valid bits and stage enables
   epsc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // day number, seconds of day, cycle number
   epsc_day_split u_split (
      .clock       (clock),
      .ctrl        (ctrl),
      .req_seconds (req_seconds),
      .days        (days),
      .cycle       (cycle),
      .tod         (tod)
   );

   // calendar date
   epsc_date u_date (
      .clock (clock),
      .ctrl  (ctrl),
      .days  (days),
      .cycle (cycle),
      .year  (rsp_year),
      .month (rsp_month),
      .day   (rsp_day)
   );

   // time of day
   epsc_clock u_clock (
      .clock  (clock),
      .ctrl   (ctrl),
      .tod    (tod),
      .hour   (rsp_hour),
      .minute (rsp_minute),
      .second (rsp_second)
   );

endmodule

### rtl/epsc_checker.sv
// ----------------------------------------------------------------------------
// epsc_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module epsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second
);

   // pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input only backs up when the result side is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result side is free");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_year) && $stable(rsp_month)
         && $stable(rsp_day) && $stable(rsp_hour) && $stable(rsp_minute)
         && $stable(rsp_second)))
      else $error("stalled result changed");

   // result fields in calendar range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1
         && rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59
         && rsp_year <= 8'd136))
      else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar epsc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_year    (rsp_year),
   .rsp_month   (rsp_month),
   .rsp_day     (rsp_day),
   .rsp_hour    (rsp_hour),
   .rsp_minute  (rsp_minute),
   .rsp_second  (rsp_second)
);

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for epoch_seconds_to_calendar. Seconds values are sent
// over the req channel with random idle gaps. An independent calendar
// predictor queues the expected date and time for each accepted transfer,
// and every rsp transfer is compared field by field against the oldest
// entry. Covers corner dates, leap days (2100 included), year, month and day
// edges, long output stalls and random seconds over the full 32-bit range.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HalfPeriod = 6;
   localparam int ResetCycles = 10;
   localparam int DrainCycles = 20;
   localparam longint CycleLimit = 500000;
   localparam int RandomBlocks = 17;
   localparam int BlockItems = 50;

   // expected calendar fields of one result
   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } cal_time_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_seconds;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;

   cal_time_type pending_dates [$];
   int unsigned mismatch_count;
   int unsigned unexpected_count;
   int unsigned dates_sent;
   int unsigned dates_checked;
   longint      cycle_count;
   bit          sender_idle;
   bit          receiver_idle;
   int unsigned rsp_hold_cycles;

   epoch_seconds_to_calendar u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_seconds(req_seconds),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_year   (rsp_year),
      .rsp_month  (rsp_month),
      .rsp_day    (rsp_day),
      .rsp_hour   (rsp_hour),
      .rsp_minute (rsp_minute),
      .rsp_second (rsp_second)
   );

   // clock
   initial clock = 1'b0;
   always #HalfPeriod clock = ~clock;

   // days of the year that come before month index idx (0 is January)
   function automatic int unsigned days_before_month(input bit leap, input int unsigned idx);
      int unsigned first;
      case (idx)
         0:       first = 0;
         1:       first = 31;
         2:       first = 59;
         3:       first = 90;
         4:       first = 120;
         5:       first = 151;
         6:       first = 181;
         7:       first = 212;
         8:       first = 243;
         9:       first = 273;
         10:      first = 304;
         11:      first = 334;
         default: first = 365;
      endcase
      if (idx >= 2 && leap) begin
         first = first + 1;
      end
      return first;
   endfunction

   // calendar predictor: every fourth year leap, no century rule
   function automatic cal_time_type calendar_from_seconds(input logic [31:0] seconds);
      cal_time_type result;
      int unsigned days;
      int unsigned day_seconds;
      int unsigned four_year;
      int unsigned cycle_day;
      int unsigned year_in_cycle;
      int unsigned day_of_year;
      int unsigned month;
      bit          leap;
      days = seconds / 32'd86400;
      day_seconds = seconds % 32'd86400;
      four_year = days / 1461;
      cycle_day = days % 1461;
      if (cycle_day < 366) begin
         year_in_cycle = 0;
         day_of_year = cycle_day;
      end else begin
         year_in_cycle = (cycle_day - 1) / 365;
         day_of_year = cycle_day - 366 - (year_in_cycle - 1) * 365;
      end
      leap = (year_in_cycle == 0);
      month = 1;
      while (month < 12 && day_of_year >= days_before_month(leap, month)) begin
         month = month + 1;
      end
      result.year = 8'(four_year * 4 + year_in_cycle);
      result.month = 4'(month);
      result.day = 5'(day_of_year - days_before_month(leap, month - 1) + 1);
      result.hour = 5'(day_seconds / 3600);
      result.minute = 6'((day_seconds % 3600) / 60);
      result.second = 6'(day_seconds % 60);
      return result;
   endfunction

   // idle length: mostly short, now and then long
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         return $urandom_range(1, 3);
      end else if (pick < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(11, 40);
   endfunction

   // seconds value aimed at calendar edges, or fully random
   function automatic logic [31:0] random_seconds();
      longint unsigned total;
      int unsigned     kind;
      int unsigned     day_count;
      int unsigned     day_seconds;
      int unsigned     cycle_base;
      int unsigned     year_start;
      int unsigned     month_idx;
      kind = $urandom_range(0, 9);
      cycle_base = $urandom_range(0, 33) * 1461;
      day_seconds = $urandom_range(0, 86399);
      case (kind)
         0, 1, 2: begin
            return $urandom;
         end
         3, 4: begin
            // around midnight
            day_count = $urandom_range(0, 49710);
            case ($urandom_range(0, 3))
               0:       day_seconds = 0;
               1:       day_seconds = 1;
               2:       day_seconds = 86398;
               default: day_seconds = 86399;
            endcase
         end
         5, 6: begin
            // first and last days of years inside a four-year cycle
            case ($urandom_range(0, 7))
               0:       day_count = cycle_base;
               1:       day_count = cycle_base + 365;
               2:       day_count = cycle_base + 366;
               3:       day_count = cycle_base + 730;
               4:       day_count = cycle_base + 731;
               5:       day_count = cycle_base + 1095;
               6:       day_count = cycle_base + 1096;
               default: day_count = cycle_base + 1460;
            endcase
         end
         7, 8: begin
            // last day of a month or first day of the next
            case ($urandom_range(0, 3))
               0:       year_start = 0;
               1:       year_start = 366;
               2:       year_start = 731;
               default: year_start = 1096;
            endcase
            month_idx = $urandom_range(1, 11);
            day_count = cycle_base + year_start
                      + days_before_month(year_start == 0, month_idx)
                      + $urandom_range(0, 1) - 1;
         end
         default: begin
            // top of the range
            return 32'hFFFF_FFFF - $urandom_range(0, 86400 * 40);
         end
      endcase
      total = 64'(day_count) * 64'd86400 + 64'(day_seconds);
      if (total > 64'h0000_0000_FFFF_FFFF) begin
         total = 64'($urandom);
      end
      return total[31:0];
   endfunction

   task automatic check_field(input string name, input int unsigned expected,
                              input int unsigned actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
         mismatch_count++;
      end
   endtask

   // predict on each req transfer, check on each rsp transfer
   always @(posedge clock) begin : result_check
      cal_time_type expected_date;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_dates.push_back(calendar_from_seconds(req_seconds));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_dates.size() == 0) begin
               $error("result transfer with no expected date pending");
               unexpected_count++;
            end else begin
               expected_date = pending_dates.pop_front();
               check_field("year", expected_date.year, rsp_year);
               check_field("month", expected_date.month, rsp_month);
               check_field("day", expected_date.day, rsp_day);
               check_field("hour", expected_date.hour, rsp_hour);
               check_field("minute", expected_date.minute, rsp_minute);
               check_field("second", expected_date.second, rsp_second);
               dates_checked++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("** epoch_seconds_to_calendar: FAILED **");
         $finish;
      end
   end

   // output side: random stalls plus the long hold when requested
   initial begin : receiver
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_idle && $urandom_range(0, 99) < 30) begin
            stall_left = idle_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // one req transfer, called and returning at a falling edge
   task automatic send_seconds(input logic [31:0] seconds);
      int unsigned gap;
      req_valid <= 1'b1;
      req_seconds <= seconds;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      dates_sent++;
      @(negedge clock);
      if (sender_idle && $urandom_range(0, 99) < 30) begin
         gap = idle_length();
         req_valid <= 1'b0;
         req_seconds <= $urandom;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_for_results();
      while (pending_dates.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // corner dates, back to back
   task automatic test_corner_dates();
      logic [31:0] corner_values [21];
      corner_values = '{
         32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         32'd5097600,     // 2000-02-29
         32'd5184000,     // 2000-03-01
         32'd31622399,    // last second of 2000
         32'd31622400,    // first second of 2001
         32'd36719999,    // end of 2001-02-28
         32'd63158400,    // 2002-01-01
         32'd94694400,    // 2003-01-01
         32'd126230400,   // 2004-01-01, second four-year cycle
         32'd3160857600,  // 2100-02-29, century year still leap
         32'd3160944000,  // 2100-03-01
         32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      foreach (corner_values[i]) begin
         send_seconds(corner_values[i]);
      end
   endtask

   // random seconds in stretches with and without idling
   task automatic test_random_dates();
      for (int blk = 0; blk < RandomBlocks; blk++) begin
         sender_idle = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < BlockItems; n++) begin
            send_seconds(random_seconds());
         end
      end
   endtask

   // long output hold while the sender keeps offering transfers
   task automatic test_output_backpressure();
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      rsp_hold_cycles = 80;
      for (int n = 0; n < 40; n++) begin
         send_seconds(random_seconds());
      end
   endtask

   // sender pauses until every pending date has come back
   task automatic test_drain_pause();
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      for (int n = 0; n < 20; n++) begin
         send_seconds(random_seconds());
      end
      req_valid <= 1'b0;
      wait_for_results();
      for (int n = 0; n < 20; n++) begin
         send_seconds(random_seconds());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_seconds = '0;
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      rsp_hold_cycles = 0;
      mismatch_count = 0;
      unexpected_count = 0;
      dates_sent = 0;
      dates_checked = 0;
      cycle_count = 0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_corner_dates();
      test_output_backpressure();
      test_random_dates();
      test_drain_pause();

      req_valid <= 1'b0;
      wait_for_results();
      repeat (DrainCycles) @(negedge clock);

      $display("converted %0d timestamps, %0d results checked", dates_sent, dates_checked);
      $display("corner dates, leap days incl. 2100, year and month edges, stalls, random range");
      if (mismatch_count == 0 && unexpected_count == 0 && pending_dates.size() == 0) begin
         $display("** epoch_seconds_to_calendar: PASSED **");
      end else begin
         $display("** epoch_seconds_to_calendar: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
rtl/epsc_pkg.sv
rtl/epsc_pipe_ctrl.sv
rtl/epsc_day_split.sv
rtl/epsc_date.sv
rtl/epsc_clock.sv
rtl/epoch_seconds_to_calendar.sv
rtl/epsc_checker.sv
test/testbench.sv
